[rtl/core/ogih_pkg.sv]
// Package of shared constants, types and boundary tables for the gradient histogram unit.
`timescale 1ns / 1ps
package ogih_pkg;

   localparam int BINS_DEFAULT      = 9;
   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int NSUM              = 10;
   localparam int IW                = 33;
   localparam logic [IW-1:0] SAT33  = {IW{1'b1}};

   typedef logic [IW-1:0] integ_type;
   typedef integ_type [NSUM-1:0] integ_vec_type;

   // Front end result handed to the accumulator.
   typedef struct packed {
      logic [12:0] mag;
      logic [3:0]  bin;
      logic        row_end;
      logic        frame_end;
   } grad_type;

   function automatic logic signed [15:0] bound_cos(input int nb, input int j);
      logic signed [15:0] r;
      r = '0;
      case (nb)
         2: case (j) 0: r = 11585; 1: r = -11585; default: r = '0; endcase
         3: case (j) 0: r = 14189; 1: r = 0; 2: r = -14189; default: r = '0; endcase
         4: case (j) 0: r = 15137; 1: r = 6270; 2: r = -6270; 3: r = -15137;
               default: r = '0; endcase
         5: case (j) 0: r = 15582; 1: r = 9630; 2: r = 0; 3: r = -9630; 4: r = -15582;
               default: r = '0; endcase
         6: case (j) 0: r = 15826; 1: r = 11585; 2: r = 4240; 3: r = -4240;
               4: r = -11585; 5: r = -15826; default: r = '0; endcase
         7: case (j) 0: r = 15973; 1: r = 12810; 2: r = 7109; 3: r = 0; 4: r = -7109;
               5: r = -12810; 6: r = -15973; default: r = '0; endcase
         8: case (j) 0: r = 16069; 1: r = 13623; 2: r = 9102; 3: r = 3196;
               4: r = -3196; 5: r = -9102; 6: r = -13623; 7: r = -16069;
               default: r = '0; endcase
         9: case (j) 0: r = 16135; 1: r = 14189; 2: r = 10531; 3: r = 5604; 4: r = 0;
               5: r = -5604; 6: r = -10531; 7: r = -14189; 8: r = -16135;
               default: r = '0; endcase
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [15:0] bound_sin(input int nb, input int j);
      logic signed [15:0] r;
      r = '0;
      case (nb)
         2: case (j) 0: r = 11585; 1: r = 11585; default: r = '0; endcase
         3: case (j) 0: r = 8192; 1: r = 16384; 2: r = 8192; default: r = '0; endcase
         4: case (j) 0: r = 6270; 1: r = 15137; 2: r = 15137; 3: r = 6270;
               default: r = '0; endcase
         5: case (j) 0: r = 5063; 1: r = 13255; 2: r = 16384; 3: r = 13255; 4: r = 5063;
               default: r = '0; endcase
         6: case (j) 0: r = 4240; 1: r = 11585; 2: r = 15826; 3: r = 15826;
               4: r = 11585; 5: r = 4240; default: r = '0; endcase
         7: case (j) 0: r = 3646; 1: r = 10215; 2: r = 14761; 3: r = 16384;
               4: r = 14761; 5: r = 10215; 6: r = 3646; default: r = '0; endcase
         8: case (j) 0: r = 3196; 1: r = 9102; 2: r = 13623; 3: r = 16069;
               4: r = 16069; 5: r = 13623; 6: r = 9102; 7: r = 3196; default: r = '0; endcase
         9: case (j) 0: r = 2845; 1: r = 8192; 2: r = 12551; 3: r = 15396; 4: r = 16384;
               5: r = 15396; 6: r = 12551; 7: r = 8192; 8: r = 2845; default: r = '0; endcase
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic integ_type sat_add(input integ_type a, input integ_type b);
      logic [IW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[IW] ? SAT33 : s[IW-1:0];
   endfunction

endpackage

[rtl/core/ogih_gradient.sv]
// Gradient front end: differences, orientation bin and bit-serial rounded square root.
`timescale 1ns / 1ps
module ogih_gradient import ogih_pkg::*; #(
   parameter int BINS = BINS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [7:0] pixel_left,
   input  logic [7:0] pixel_right,
   input  logic [7:0] pixel_up,
   input  logic [7:0] pixel_down,
   input  logic       row_end,
   input  logic       frame_end,
   output logic       done,
   output grad_type   grad
);

   logic [25:0] v_ff, v_in;
   logic [25:0] r_ff, r_in;
   logic [3:0]  step_ff, step_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [3:0]  bin_ff, bin_in;
   logic        re_ff, fe_ff;

   logic signed [9:0]  dx, dy, fx, fy;
   logic [16:0]        sq;
   logic [3:0]         cnt;
   logic signed [31:0] t;
   logic [27:0]        bitv;
   logic [27:0]        trial;

   always_comb begin
      dx = $signed({2'b00, pixel_right}) - $signed({2'b00, pixel_left});
      dy = $signed({2'b00, pixel_down}) - $signed({2'b00, pixel_up});
      sq = 17'(dx * dx) + 17'(dy * dy);
      if (dy < 0 || (dy == 0 && dx < 0)) begin
         fx = -dx;
         fy = -dy;
      end else begin
         fx = dx;
         fy = dy;
      end
      cnt = '0;
      for (int j = 0; j < BINS; j++) begin
         t = 32'(fy * bound_cos(BINS, j)) - 32'(fx * bound_sin(BINS, j));
         if (t >= 0) cnt = cnt + 4'd1;
      end
   end

   // One result bit per cycle over thirteen steps.
   always_comb begin
      v_in = v_ff;
      r_in = r_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      bin_in = bin_ff;
      bitv = 28'd1 << {step_ff, 1'b0};
      trial = {2'd0, r_ff} + bitv;
      if (start) begin
         v_in = {1'b0, sq, 8'd0};
         r_in = '0;
         step_in = 4'd12;
         busy_in = 1'b1;
         bin_in = (cnt == 4'd0) ? 4'(BINS - 1) : cnt - 4'd1;
      end else if (busy_ff) begin
         if ({2'b00, v_ff} >= trial) begin
            v_in = 26'({2'b00, v_ff} - trial);
            r_in = 26'((r_ff >> 1) + bitv);
         end else begin
            r_in = r_ff >> 1;
         end
         if (step_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff <= v_in;
      r_ff <= r_in;
      step_ff <= step_in;
      bin_ff <= bin_in;
      if (start) begin
         re_ff <= row_end;
         fe_ff <= frame_end;
      end
   end

   assign done = done_ff;
   assign grad.mag = (v_ff > r_ff) ? 13'(r_ff + 26'd1) : r_ff[12:0];
   assign grad.bin = bin_ff;
   assign grad.row_end = re_ff;
   assign grad.frame_end = fe_ff;

endmodule

[rtl/core/ogih_accum.sv]
// Row sums and the previous-row integral memory, read-modify-write per pixel.
`timescale 1ns / 1ps
module ogih_accum import ogih_pkg::*; #(
   parameter int BINS      = BINS_DEFAULT,
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  grad_type      grad,
   output logic          done,
   output integ_vec_type result
);

   localparam int CW = $clog2(MAX_WIDTH);

   integ_vec_type mem [MAX_WIDTH];
   integ_vec_type rd_ff;
   integ_vec_type row_sum_ff, row_sum_in;
   logic [CW-1:0] col_ff, col_in;
   logic          first_ff, first_in;
   logic          phase_ff;
   integ_vec_type wr;

   always_ff @(posedge clock) begin
      if (start) rd_ff <= mem[col_ff];
      if (phase_ff) mem[col_ff] <= wr;
   end

   always_comb begin
      row_sum_in = row_sum_ff;
      col_in = col_ff;
      first_in = first_ff;
      for (int i = 0; i < NSUM; i++) begin
         if (i == NSUM - 1 || i == int'(grad.bin))
            row_sum_in[i] = sat_add(row_sum_ff[i], {20'd0, grad.mag});
      end
      for (int i = 0; i < NSUM; i++) begin
         wr[i] = sat_add(first_ff ? '0 : rd_ff[i], row_sum_in[i]);
         if (i < NSUM - 1 && i >= BINS) wr[i] = '0;
      end
      if (grad.row_end || grad.frame_end) begin
         row_sum_in = '0;
         col_in = '0;
         first_in = grad.frame_end;
      end else if (col_ff != CW'(MAX_WIDTH - 1)) begin
         col_in = col_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_sum_ff <= '0;
         col_ff <= '0;
         first_ff <= 1'b1;
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= start;
         if (phase_ff) begin
            row_sum_ff <= row_sum_in;
            col_ff <= col_in;
            first_ff <= first_in;
         end
      end
      if (phase_ff) result <= wr;
   end

   logic done_ff;
   always_ff @(posedge clock) begin
      if (reset) done_ff <= 1'b0;
      else done_ff <= phase_ff;
   end
   assign done = done_ff;

endmodule

[rtl/core/oriented_gradient_integral_histogram_unit.sv]
// Top level of the oriented-gradient integral histogram unit.
//  channel | direction | payload
//  req     | in        | four neighbour pixels, row_end in tlast, frame_end in tuser
//  rsp     | out       | nine bin integrals and magnitude integral, flags in tlast and tuser
// rsp_tvalid rises after 13 square root steps (one result bit per cycle), the memory read,
// the write back into the column entry and the result register, and the registered output
// flag. A new request cannot be taken before the previous result has left the result register.
// A new request is accepted only when the result register is free and nothing is in flight.
// Reset is synchronous; row sums, column and first-row flag clear, memory is not cleared.
`timescale 1ns / 1ps
module oriented_gradient_integral_histogram_unit import ogih_pkg::*; #(
   parameter int BINS      = BINS_DEFAULT,
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // pixel_left, pixel_right, pixel_up, pixel_down
   input  logic         req_tlast,   // row_end
   input  logic         req_tuser,   // frame_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [335:0] rsp_tdata,   // bin0..bin8 integrals, magnitude integral
   output logic         rsp_tlast,   // row_end_out
   output logic         rsp_tuser    // frame_end_out
);

   logic          busy_ff, busy_in;
   logic          g_done, a_done, start;
   grad_type      grad;
   integ_vec_type result;
   logic          full_ff;
   logic          re_ff, fe_ff;

   assign req_tready = !busy_ff && !full_ff;
   assign start = req_tvalid && req_tready;

   ogih_gradient #(.BINS(BINS)) u_grad (
      .clock, .reset, .start,
      .pixel_left(req_tdata[7:0]), .pixel_right(req_tdata[15:8]),
      .pixel_up(req_tdata[23:16]), .pixel_down(req_tdata[31:24]),
      .row_end(req_tlast), .frame_end(req_tuser),
      .done(g_done), .grad
   );

   ogih_accum #(.BINS(BINS), .MAX_WIDTH(MAX_WIDTH)) u_acc (
      .clock, .reset, .start(g_done), .grad, .done(a_done), .result
   );

   always_comb begin
      busy_in = busy_ff;
      if (start) busy_in = 1'b1;
      else if (a_done) busy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         full_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (a_done) full_ff <= 1'b1;
         else if (rsp_tready) full_ff <= 1'b0;
      end
      if (g_done) begin
         re_ff <= grad.row_end;
         fe_ff <= grad.frame_end;
      end
   end

   assign rsp_tvalid = full_ff;
   assign rsp_tdata = {6'd0, result};
   assign rsp_tlast = re_ff;
   assign rsp_tuser = fe_ff;

endmodule
